### design/assert_macros.svh
// Assertion macros shared by the line path stepper RTL.
// Included by the top level; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LPS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("line path stepper check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("line path stepper check failed");

`endif

### design/lps_pkg.sv
// Shared types and constants for the line path stepper.
// No dependencies.
package lps_pkg;

  // Tile coordinates are reported masked to this many bits.
  localparam int TILE_BITS = 9;

  // Beat kind carried on in_tuser.
  typedef enum logic [0:0] {
    MODE_LOAD = 1'b0,
    MODE_TICK = 1'b1
  } lps_mode_e;

endpackage

### design/lps_step.sv
// Next-state logic of the line stepper: load a new line or advance one tick.
// Depends on lps_pkg.
module lps_step
  import lps_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  lps_mode_e                      mode,
  input  logic [COORD_BITS-1:0]          src_x,
  input  logic [COORD_BITS-1:0]          src_y,
  input  logic [COORD_BITS-1:0]          dst_x,
  input  logic [COORD_BITS-1:0]          dst_y,
  input  logic [COORD_BITS-1:0]          cur_x_r,
  input  logic [COORD_BITS-1:0]          cur_y_r,
  input  logic [COORD_BITS-1:0]          goal_x_r,
  input  logic [COORD_BITS-1:0]          goal_y_r,
  input  logic signed [COORD_BITS+1:0]   remain_x_r,
  input  logic signed [COORD_BITS+1:0]   remain_y_r,
  input  logic signed [COORD_BITS+3:0]   step_error_r,
  input  logic                           major_is_y_r,
  output logic [COORD_BITS-1:0]          cur_x_nxt,
  output logic [COORD_BITS-1:0]          cur_y_nxt,
  output logic [COORD_BITS-1:0]          goal_x_nxt,
  output logic [COORD_BITS-1:0]          goal_y_nxt,
  output logic signed [COORD_BITS+1:0]   remain_x_nxt,
  output logic signed [COORD_BITS+1:0]   remain_y_nxt,
  output logic signed [COORD_BITS+3:0]   step_error_nxt,
  output logic                           major_is_y_nxt,
  output logic                           arrived
);

  localparam int RB = COORD_BITS + 2;
  localparam int EB = COORD_BITS + 4;

  function automatic logic [COORD_BITS-1:0] step_toward(
    input logic [COORD_BITS-1:0] pos,
    input logic [COORD_BITS-1:0] goal
  );
    logic [COORD_BITS-1:0] res;
    if (pos < goal) begin
      res = pos + COORD_BITS'(1);
    end else if (pos > goal) begin
      res = pos - COORD_BITS'(1);
    end else begin
      res = pos;
    end
    return res;
  endfunction

  logic [COORD_BITS-1:0] ax, ay;
  logic [EB-1:0]         ax_e, ay_e;
  logic [RB:0]           remain_sum;
  logic                  at_goal;
  logic [EB-1:0]         rx_e, ry_e, err_add, err_new;
  logic                  minor_step;

  always_comb begin
    ax = (src_x > dst_x) ? (src_x - dst_x) : (dst_x - src_x);
    ay = (src_y > dst_y) ? (src_y - dst_y) : (dst_y - src_y);
    ax_e = EB'(ax);
    ay_e = EB'(ay);

    remain_sum = {remain_x_r[RB-1], remain_x_r} + {remain_y_r[RB-1], remain_y_r};
    at_goal    = remain_sum[RB] || (remain_sum == '0);

    rx_e = {{2{remain_x_r[RB-1]}}, remain_x_r};
    ry_e = {{2{remain_y_r[RB-1]}}, remain_y_r};

    // Error term: add twice the minor delta, less twice the major one after a minor step.
    if (!major_is_y_r) begin
      err_add = step_error_r[EB-1] ? (ry_e << 1) : ((ry_e - rx_e) << 1);
    end else begin
      err_add = step_error_r[EB-1] ? (rx_e << 1) : ((rx_e - ry_e) << 1);
    end
    err_new    = step_error_r + err_add;
    minor_step = !err_new[EB-1];

    cur_x_nxt      = cur_x_r;
    cur_y_nxt      = cur_y_r;
    goal_x_nxt     = goal_x_r;
    goal_y_nxt     = goal_y_r;
    remain_x_nxt   = remain_x_r;
    remain_y_nxt   = remain_y_r;
    step_error_nxt = step_error_r;
    major_is_y_nxt = major_is_y_r;
    arrived        = 1'b0;

    unique case (mode)
      MODE_LOAD: begin
        cur_x_nxt      = src_x;
        cur_y_nxt      = src_y;
        goal_x_nxt     = dst_x;
        goal_y_nxt     = dst_y;
        remain_x_nxt   = RB'(ax);
        remain_y_nxt   = RB'(ay);
        major_is_y_nxt = (ax < ay);
        if (ax < ay) begin
          step_error_nxt = (ax_e << 1) - ay_e;
        end else if (ay < ax) begin
          step_error_nxt = (ay_e << 1) - ax_e;
        end else begin
          step_error_nxt = '0;
        end
        arrived = (ax == '0) && (ay == '0);
      end
      MODE_TICK: begin
        if (at_goal) begin
          arrived = 1'b1;
        end else begin
          step_error_nxt = err_new;
          if (!major_is_y_r) begin
            remain_x_nxt = remain_x_r - RB'(1);
            cur_x_nxt    = step_toward(cur_x_r, goal_x_r);
            if (minor_step) begin
              remain_y_nxt = remain_y_r - RB'(1);
              cur_y_nxt    = step_toward(cur_y_r, goal_y_r);
            end
          end else begin
            remain_y_nxt = remain_y_r - RB'(1);
            cur_y_nxt    = step_toward(cur_y_r, goal_y_r);
            if (minor_step) begin
              remain_x_nxt = remain_x_r - RB'(1);
              cur_x_nxt    = step_toward(cur_x_r, goal_x_r);
            end
          end
        end
      end
      default: begin
        arrived = 1'b0;
      end
    endcase
  end

endmodule

### design/lps_obuf.sv
// Two-entry result buffer: output register plus skid register.
// No dependencies.
module lps_obuf #(
  parameter int WIDTH = 48
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             can_push,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  logic             main_valid_r, main_valid_nxt;
  logic             skid_valid_r, skid_valid_nxt;
  logic [WIDTH-1:0] main_data_r, main_data_nxt;
  logic [WIDTH-1:0] skid_data_r, skid_data_nxt;
  logic             main_free;

  assign can_push  = !skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_data_r;
  assign main_free = !main_valid_r || out_ready;

  always_comb begin
    main_valid_nxt = main_valid_r;
    main_data_nxt  = main_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (main_free) begin
      // Refill the output register, oldest beat first.
      if (skid_valid_r) begin
        main_valid_nxt = 1'b1;
        main_data_nxt  = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        main_valid_nxt = push;
        main_data_nxt  = push_data;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_data_r <= main_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

endmodule

### design/line_path_stepper_unit.sv
// Top level of the line path stepper: state registers, tile divide, result buffer.
// Depends on lps_pkg, lps_step, lps_obuf and assert_macros.svh.
//
//  channel | direction | tdata                          | tuser
//  --------+-----------+--------------------------------+------------------
//  in_*    | slave     | src_x, src_y, dst_x, dst_y     | mode (load/tick)
//  out_*   | master    | pos_x, pos_y, tile_x, tile_y,  | none
//          |           | arrived                        |
//
// Flow: one beat per clock in both directions while neither side stalls; each result is
// registered as its input beat is taken. The line state and the result register are
// updated in the same edge, so a tick depends only on state left by the previous beat.
// Reset: rst_n (synchronous) clears the line state to zero and empties the buffer.
// Stalls: an output register and a skid register hold up to two results; in_tready drops
// only when both are full, so one more beat is taken while a result waits.
`include "assert_macros.svh"

module line_path_stepper_unit
  import lps_pkg::*;
#(
  parameter int SUBTILE    = 15,
  parameter int COORD_BITS = 12
) (
  input  logic clk,
  input  logic rst_n,

  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // src_x, src_y, dst_x, dst_y from bit 0 up, zero padding to a whole byte
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]      in_tdata,
  // mode
  input  logic                                   in_tuser,

  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // pos_x, pos_y, tile_x, tile_y, arrived from bit 0 up, zero padding to a whole byte
  output logic [((2*COORD_BITS+2*9+1+7)/8)*8-1:0] out_tdata
);

  localparam int RB      = COORD_BITS + 2;
  localparam int EB      = COORD_BITS + 4;
  localparam int RES_W   = 2 * COORD_BITS + 2 * TILE_BITS + 1;
  localparam int OUT_W   = ((2 * COORD_BITS + 2 * 9 + 1 + 7) / 8) * 8;
  // Reciprocal for the divide by SUBTILE: rounded up, exact for every coordinate.
  localparam int     SHIFT   = COORD_BITS + 7;
  localparam int     RECIP_W = SHIFT + 1;
  localparam longint RECIP_L = ((longint'(1) << SHIFT) + SUBTILE - 1) / SUBTILE;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
  localparam int     PROD_W  = COORD_BITS + RECIP_W;

  logic in_acc;

  // Input fields
  logic [COORD_BITS-1:0] src_x, src_y, dst_x, dst_y;
  lps_mode_e             mode;

  // Line state
  logic [COORD_BITS-1:0] cur_x_r, cur_y_r, goal_x_r, goal_y_r;
  logic [COORD_BITS-1:0] cur_x_nxt, cur_y_nxt, goal_x_nxt, goal_y_nxt;
  logic signed [RB-1:0]  remain_x_r, remain_y_r, remain_x_nxt, remain_y_nxt;
  logic signed [EB-1:0]  step_error_r, step_error_nxt;
  logic                  major_is_y_r, major_is_y_nxt;
  logic                  arrived;

  // Result
  logic [PROD_W-1:0]     prod_x, prod_y;
  logic [TILE_BITS-1:0]  tile_x, tile_y;
  logic [OUT_W-1:0]      res_data;
  logic                  buf_can_push;

  // Beat classes watched by the checks below
  logic                  load_acc, hold_tick;

  assign src_x = in_tdata[0*COORD_BITS +: COORD_BITS];
  assign src_y = in_tdata[1*COORD_BITS +: COORD_BITS];
  assign dst_x = in_tdata[2*COORD_BITS +: COORD_BITS];
  assign dst_y = in_tdata[3*COORD_BITS +: COORD_BITS];
  assign mode  = lps_mode_e'(in_tuser);

  assign in_tready = buf_can_push;
  assign in_acc    = in_tvalid && in_tready;

  lps_step #(
    .COORD_BITS (COORD_BITS)
  ) u_step (
    .mode           (mode),
    .src_x          (src_x),
    .src_y          (src_y),
    .dst_x          (dst_x),
    .dst_y          (dst_y),
    .cur_x_r        (cur_x_r),
    .cur_y_r        (cur_y_r),
    .goal_x_r       (goal_x_r),
    .goal_y_r       (goal_y_r),
    .remain_x_r     (remain_x_r),
    .remain_y_r     (remain_y_r),
    .step_error_r   (step_error_r),
    .major_is_y_r   (major_is_y_r),
    .cur_x_nxt      (cur_x_nxt),
    .cur_y_nxt      (cur_y_nxt),
    .goal_x_nxt     (goal_x_nxt),
    .goal_y_nxt     (goal_y_nxt),
    .remain_x_nxt   (remain_x_nxt),
    .remain_y_nxt   (remain_y_nxt),
    .step_error_nxt (step_error_nxt),
    .major_is_y_nxt (major_is_y_nxt),
    .arrived        (arrived)
  );

  // Hold the line state; advance it on every accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r      <= '0;
      cur_y_r      <= '0;
      goal_x_r     <= '0;
      goal_y_r     <= '0;
      remain_x_r   <= '0;
      remain_y_r   <= '0;
      step_error_r <= '0;
      major_is_y_r <= 1'b0;
    end else if (in_acc) begin
      cur_x_r      <= cur_x_nxt;
      cur_y_r      <= cur_y_nxt;
      goal_x_r     <= goal_x_nxt;
      goal_y_r     <= goal_y_nxt;
      remain_x_r   <= remain_x_nxt;
      remain_y_r   <= remain_y_nxt;
      step_error_r <= step_error_nxt;
      major_is_y_r <= major_is_y_nxt;
    end
  end

  // Tile = position / SUBTILE via multiply by the rounded-up reciprocal, then shift.
  assign prod_x = PROD_W'(cur_x_nxt) * PROD_W'(RECIP);
  assign prod_y = PROD_W'(cur_y_nxt) * PROD_W'(RECIP);
  assign tile_x = prod_x[SHIFT +: TILE_BITS];
  assign tile_y = prod_y[SHIFT +: TILE_BITS];

  assign res_data = OUT_W'({arrived, tile_y, tile_x, cur_y_nxt, cur_x_nxt});

  lps_obuf #(
    .WIDTH (OUT_W)
  ) u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_acc),
    .push_data (res_data),
    .can_push  (buf_can_push),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

  assign load_acc  = in_acc && (mode == MODE_LOAD);
  assign hold_tick = in_acc && (mode == MODE_TICK) && arrived;

  // A load places the position at the source.
  `LPS_ASSERT_NEXT(a_load_sets_pos, clk, rst_n, load_acc, {cur_y_r, cur_x_r} == $past({src_y, src_x}))
  // A tick that reports arrival leaves the position where it was.
  `LPS_ASSERT_NEXT(a_arrived_holds, clk, rst_n, hold_tick, $stable({cur_y_r, cur_x_r}))
  // Input back-pressure only while a result is on offer.
  `LPS_ASSERT_NOW(a_stall_has_beat, clk, rst_n, !in_tready, out_tvalid)
  // Every accepted beat leaves a result to deliver.
  `LPS_ASSERT_NEXT(a_accept_gives_beat, clk, rst_n, in_acc, out_tvalid)

  // Result width check on every accepted beat: the packed result fits the port.
  localparam int RES_SPARE = OUT_W - RES_W;
  `LPS_ASSERT_NOW(a_res_fits, clk, rst_n, in_acc, RES_SPARE >= 0)

endmodule

### bench/tb_line_path_stepper_unit.sv
`timescale 1ns / 100ps
// Self-checking bench for line_path_stepper_unit: drives load and tick beats, predicts
// every position/tile/arrival result and compares it with the output stream.
// Depends on lps_pkg and the line_path_stepper_unit RTL only.

module tb_line_path_stepper_unit;
  import lps_pkg::*;

  localparam int IN_W          = 48;
  localparam int OUT_W         = 48;
  localparam int SUBTILE_UNITS = 15;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int RANDOM_BEATS  = 1850;

  typedef struct {
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic [8:0]  tile_x;
    logic [8:0]  tile_y;
    logic        arrived;
  } path_point_t;

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  // src_x, src_y, dst_x, dst_y from bit 0 up
  logic [IN_W-1:0]  in_tdata   = '0;
  // mode
  logic             in_tuser   = MODE_LOAD;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  // pos_x, pos_y, tile_x, tile_y, arrived from bit 0 up, zero padding on top
  logic [OUT_W-1:0] out_tdata;

  // Shadow of the line state, advanced once per accepted beat.
  logic        [11:0] path_x, path_y, target_x, target_y;
  logic signed [13:0] left_x, left_y;
  logic signed [15:0] slope_err;
  logic               steep;

  path_point_t expected_points[$];
  bit          last_arrived;
  bit          offering;
  bit          idling;
  int          beats_sent;
  int          mismatches;
  int          hold_left;
  int          stall_left;
  int          cycles;

  line_path_stepper_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Step one coordinate a single unit towards its goal; hold it once there.
  function automatic logic [11:0] nudge_toward(logic [11:0] p, logic [11:0] g);
    if (p < g) return p + 12'd1;
    if (p > g) return p - 12'd1;
    return p;
  endfunction

  // Work out the result of one beat and move the shadow state on.
  function automatic path_point_t advance_path(lps_mode_e mode, logic [IN_W-1:0] data);
    path_point_t        pt;
    logic        [11:0] sx, sy, dx, dy;
    int                 ax, ay, rx, ry, e;
    logic               arrived;
    if (mode == MODE_LOAD) begin
      sx = data[11:0];
      sy = data[23:12];
      dx = data[35:24];
      dy = data[47:36];
      ax = int'((sx > dx) ? sx - dx : dx - sx);
      ay = int'((sy > dy) ? sy - dy : dy - sy);
      path_x   = sx;
      path_y   = sy;
      target_x = dx;
      target_y = dy;
      left_x   = 14'(ax);
      left_y   = 14'(ay);
      if (ax < ay) e = 2 * ax - ay;
      else if (ay < ax) e = 2 * ay - ax;
      else e = 0;
      slope_err = 16'(e);
      steep     = (ax < ay);
      arrived   = (ax + ay == 0);
    end else begin
      rx = int'(left_x);
      ry = int'(left_y);
      if (rx + ry <= 0) begin
        arrived = 1'b1;
      end else begin
        arrived = 1'b0;
        e = int'(slope_err);
        if (!steep) begin
          e = e + ((e >= 0) ? 2 * (ry - rx) : 2 * ry);
          slope_err = 16'(e);
          left_x    = 14'(rx - 1);
          path_x    = nudge_toward(path_x, target_x);
          if (slope_err >= 0) begin
            left_y = 14'(ry - 1);
            path_y = nudge_toward(path_y, target_y);
          end
        end else begin
          e = e + ((e >= 0) ? 2 * (rx - ry) : 2 * rx);
          slope_err = 16'(e);
          left_y    = 14'(ry - 1);
          path_y    = nudge_toward(path_y, target_y);
          if (slope_err >= 0) begin
            left_x = 14'(rx - 1);
            path_x = nudge_toward(path_x, target_x);
          end
        end
      end
    end
    pt.pos_x   = path_x;
    pt.pos_y   = path_y;
    pt.tile_x  = 9'(path_x / SUBTILE_UNITS);
    pt.tile_y  = 9'(path_y / SUBTILE_UNITS);
    pt.arrived = arrived;
    return pt;
  endfunction

  function automatic logic [IN_W-1:0] line_coords(logic [11:0] sx, logic [11:0] sy,
                                                  logic [11:0] dx, logic [11:0] dy);
    return {dy, dx, sy, sx};
  endfunction

  // Pick a coordinate within reach of c, clamped to the field range.
  function automatic logic [11:0] near_coord(logic [11:0] c, int reach);
    int v;
    v = $urandom_range(0, 2 * reach);
    v = v - reach + int'(c);
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return 12'(v);
  endfunction

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    if (!idling) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  task automatic note_mismatch(string what, logic [47:0] want, logic [47:0] got);
    if (mismatches < 10)
      $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want, got);
    mismatches++;
  endtask

  // Offer one beat; keep tvalid high afterwards so back-to-back beats need no toggle.
  task automatic send_beat(lps_mode_e mode, logic [IN_W-1:0] data);
    int          gap;
    path_point_t pt;
    gap = pick_gap();
    if (gap > 0) begin
      if (offering) begin
        in_tvalid <= 1'b0;
        offering = 1'b0;
      end
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tuser  <= mode;
    offering = 1'b1;
    do @(posedge clk); while (!in_tready);
    pt = advance_path(mode, data);
    last_arrived = pt.arrived;
    expected_points.push_back(pt);
    beats_sent++;
  endtask

  // Drop tvalid before any wait that is not part of send_beat.
  task automatic release_input();
    if (offering) begin
      in_tvalid <= 1'b0;
      offering = 1'b0;
    end
  endtask

  task automatic send_tick();
    send_beat(MODE_TICK, IN_W'({$urandom(), $urandom()}));
  endtask

  task automatic send_line(logic [11:0] sx, logic [11:0] sy, logic [11:0] dx,
                           logic [11:0] dy, int ticks);
    send_beat(MODE_LOAD, line_coords(sx, sy, dx, dy));
    repeat (ticks) send_tick();
  endtask

  // Load a random line near its source; walk it to the end or abandon it early.
  task automatic run_line(int reach, bit walk_to_end);
    logic [11:0] sx, sy, dx, dy;
    int          k, n;
    sx = 12'($urandom_range(0, 4095));
    sy = 12'($urandom_range(0, 4095));
    if ($urandom_range(0, 9) == 0) begin
      // equal deltas on both axes
      k  = $urandom_range(0, reach);
      dx = (sx <= 4095 - k) ? sx + 12'(k) : sx - 12'(k);
      dy = (sy <= 4095 - k) ? sy + 12'(k) : sy - 12'(k);
    end else begin
      dx = near_coord(sx, reach);
      dy = near_coord(sy, reach);
    end
    send_beat(MODE_LOAD, line_coords(sx, sy, dx, dy));
    if (walk_to_end) begin
      n = 0;
      while (!last_arrived && n < 9000) begin
        send_tick();
        n++;
      end
      repeat ($urandom_range(0, 2)) send_tick();
    end else begin
      repeat ($urandom_range(0, 5)) send_tick();
    end
  endtask

  task automatic wait_for_results();
    while (expected_points.size() > 0) @(posedge clk);
  endtask

  // Directed cases ------------------------------------------------------------

  task automatic test_tick_before_load();
    // state is all zero after reset: arrival at the origin
    repeat (2) send_tick();
  endtask

  task automatic test_zero_length_line();
    send_line(12'd4095, 12'd4095, 12'd4095, 12'd4095, 1);
  endtask

  task automatic test_equal_deltas();
    send_line(12'd10, 12'd10, 12'd13, 12'd13, 4);
  endtask

  task automatic test_axis_at_goal();
    // vertical line: x is already at its goal and must hold
    send_line(12'd0, 12'd4095, 12'd0, 12'd4092, 4);
  endtask

  task automatic test_reverse_direction();
    // x-major line walking down on both axes, past its end
    send_line(12'd4095, 12'd100, 12'd4091, 12'd98, 5);
  endtask

  task automatic test_far_corners();
    send_line(12'd0, 12'd4095, 12'd4095, 12'd0, 2);
  endtask

  // Random and pressure phases --------------------------------------------------

  task automatic test_random_lines(int until_beats);
    int r;
    while (beats_sent < until_beats) begin
      r = $urandom_range(0, 99);
      if (r < 80) run_line($urandom_range(1, 40), 1'b1);
      else if (r < 87) run_line(4095, 1'b0);
      else if (r < 90) run_line(300, 1'b1);
      else run_line($urandom_range(1, 40), 1'b0);
    end
  endtask

  task automatic test_unbroken_stream(int until_beats);
    idling = 1'b0;
    while (beats_sent < until_beats) run_line($urandom_range(1, 20), 1'b1);
    idling = 1'b1;
  endtask

  task automatic test_output_hold_off();
    // hold the receiver off while beats keep coming, so the buffer fills
    idling    = 1'b0;
    hold_left = 80;
    run_line(30, 1'b1);
    run_line(30, 1'b1);
    idling = 1'b1;
  endtask

  task automatic test_drain_pause();
    run_line(10, 1'b1);
    release_input();
    wait_for_results();
    run_line(10, 1'b1);
  endtask

  // Receiver: random stalls, plus a long hold-off when a test asks for one.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else if (!idling) begin
      out_tready <= 1'b1;
    end else begin
      if (stall_left == 0) stall_left = pick_gap();
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    path_point_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_points.size() == 0) begin
        note_mismatch("unexpected result", 48'd0, 48'(out_tdata));
      end else begin
        want = expected_points.pop_front();
        if (out_tdata[11:0] !== want.pos_x)
          note_mismatch("pos_x", 48'(want.pos_x), 48'(out_tdata[11:0]));
        if (out_tdata[23:12] !== want.pos_y)
          note_mismatch("pos_y", 48'(want.pos_y), 48'(out_tdata[23:12]));
        if (out_tdata[32:24] !== want.tile_x)
          note_mismatch("tile_x", 48'(want.tile_x), 48'(out_tdata[32:24]));
        if (out_tdata[41:33] !== want.tile_y)
          note_mismatch("tile_y", 48'(want.tile_y), 48'(out_tdata[41:33]));
        if (out_tdata[42] !== want.arrived)
          note_mismatch("arrived", 48'(want.arrived), 48'(out_tdata[42]));
      end
    end
  end

  // Watchdog: end the run if it overstays the cycle budget.
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int waited;
    path_x    = '0;
    path_y    = '0;
    target_x  = '0;
    target_y  = '0;
    left_x    = '0;
    left_y    = '0;
    slope_err = '0;
    steep     = 1'b0;
    idling    = 1'b1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_tick_before_load();
    test_zero_length_line();
    test_equal_deltas();
    test_axis_at_goal();
    test_reverse_direction();
    test_far_corners();
    test_random_lines(900);
    test_unbroken_stream(1150);
    test_output_hold_off();
    test_drain_pause();
    test_random_lines(RANDOM_BEATS);

    release_input();
    waited = 0;
    while (expected_points.size() > 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    // let a late or stray beat show up
    repeat (8) @(posedge clk);
    if (expected_points.size() != 0)
      note_mismatch("missing results", 48'(expected_points.size()), 48'd0);

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
